// ----- rtl/wrsi_pkg.sv -----
// ----------------------------------------------------------------------------
// wrsi_pkg: shared types and constants of the windowed relative strength index
// Holds the state machine encodings, update kinds and fixed field widths.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int SERIAL_W    = 32;
    localparam int INDEX_W     = 14;
    localparam int CFG_W       = 7;
    localparam int DIGIT_COUNT = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd14;

    // Main sequencer of the top level.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_REMOVE,
        ST_ADD,
        ST_TOTAL,
        ST_START,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // Sequencer of the decimal divider.
    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SCALE,
        DV_STEP,
        DV_DONE
    } t_div_state;

    // How a bar update relates to the bars already held.
    typedef enum logic [1:0] {
        KIND_SAME,
        KIND_APPEND,
        KIND_RESTART
    } t_kind;

endpackage

// ----- rtl/wrsi_divider.sv -----
// ----------------------------------------------------------------------------
// wrsi_divider: decimal long divider for the scaled ratio
// Produces floor(up * 10000 / total) one decimal digit at a time, each digit
// found by four restoring compare-and-subtract steps.
// ----------------------------------------------------------------------------
module wrsi_divider
    import wrsi_pkg::*;
#(
    parameter int SUM_W = 38
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [SUM_W-1:0]   i_up,
    input  logic [SUM_W-1:0]   i_total,
    output logic               o_done,
    output logic [INDEX_W-1:0] o_quotient
);

    // The remainder is scaled by ten before each digit, so it needs four
    // more bits than the denominator.
    localparam int REM_W = SUM_W + 4;

    t_div_state         r_state;
    t_div_state         n_state;
    logic [REM_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_den;
    logic [INDEX_W-1:0] r_quot;
    logic [3:0]         r_digit;
    logic [1:0]         r_bit;
    logic [1:0]         r_count;

    logic               w_load;
    logic               w_scale;
    logic               w_step;
    logic [REM_W-1:0]   w_den_shift;
    logic               w_ge;
    logic [3:0]         w_digit_now;
    logic               w_last_bit;
    logic               w_last_digit;

    assign w_den_shift  = REM_W'(r_den) << r_bit;
    assign w_ge         = r_rem >= w_den_shift;
    assign w_digit_now  = r_digit | (w_ge ? (4'b0001 << r_bit) : 4'b0000);
    assign w_last_bit   = r_bit == 2'd0;
    assign w_last_digit = r_count == 2'(DIGIT_COUNT - 1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DV_IDLE: begin
                if (i_start) begin
                    n_state = DV_SCALE;
                end
            end
            DV_SCALE: begin
                n_state = DV_STEP;
            end
            DV_STEP: begin
                if (w_last_bit) begin
                    n_state = w_last_digit ? DV_DONE : DV_SCALE;
                end
            end
            DV_DONE: begin
                n_state = DV_IDLE;
            end
            default: begin
                n_state = DV_IDLE;
            end
        endcase
    end

    always_comb begin
        w_load  = 1'b0;
        w_scale = 1'b0;
        w_step  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            DV_IDLE:  w_load  = i_start;
            DV_SCALE: w_scale = 1'b1;
            DV_STEP:  w_step  = 1'b1;
            DV_DONE:  o_done  = 1'b1;
            default:  o_done  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_rem   <= REM_W'(i_up);
            r_den   <= i_total;
            r_quot  <= '0;
            r_count <= '0;
        end
        if (w_scale) begin
            // Times ten as eight plus two.
            r_rem   <= (r_rem << 3) + (r_rem << 1);
            r_bit   <= 2'd3;
            r_digit <= '0;
        end
        if (w_step) begin
            if (w_ge) begin
                r_rem <= r_rem - w_den_shift;
            end
            r_digit <= w_digit_now;
            r_bit   <= r_bit - 2'd1;
            if (w_last_bit) begin
                r_quot  <= (r_quot << 3) + (r_quot << 1) + INDEX_W'(w_digit_now);
                r_count <= r_count + 2'd1;
            end
        end
    end

    assign o_quotient = r_quot;

endmodule

// ----- rtl/windowed_relative_strength_index.sv -----
// ----------------------------------------------------------------------------
// windowed_relative_strength_index: windowed relative strength index
// An update made while a full window is held goes through the ring
// read-modify-write, the sum total and the decimal divider (skipped when
// both sums are zero) before its result is shown; an update without a
// result frees the input after the ring read-modify-write.
// Reset: synchronous, active low; clears sums and bar count, window length 14.
// ----------------------------------------------------------------------------
// The block keeps the close-minus-open differences of the last bars in a
// ring memory together with two running sums, one of up moves and one of
// down moves. Each update runs through a short sequence: the affected ring
// entry is read, the difference it held is taken out of its sum when it is
// replaced (a restart clears both sums) while the new difference is written
// in its place and then added. When a full window is held, the ratio of the
// up sum to the total is scaled to hundredths of a percent by a decimal long
// divider and the result goes to an output register, which lets the next
// update be taken while the previous result still waits on the consumer.
//
// Only one update is in flight at a time, so the ring write of one update
// always lands before the read of the next and no forwarding is needed.
// A ring entry's value is used only after the entry has been written, so the
// ring has no clearing pass and is usable right after reset.
// ----------------------------------------------------------------------------
module windowed_relative_strength_index
    import wrsi_pkg::*;
#(
    parameter int WINDOW_MAX = 64,
    parameter int PRICE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration: window length, written while the block is idle; the block itself does not enforce this.
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    // Bar update channel.
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SERIAL_W-1:0]   i_bar_serial,
    input  logic [PRICE_BITS-1:0] i_open_price,
    input  logic [PRICE_BITS-1:0] i_close_price,
    // Result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SERIAL_W-1:0]   o_result_serial,
    output logic [INDEX_W-1:0]    o_index_hundredths
);

    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = SLOT_W + 1;
    localparam int DIFF_W = PRICE_BITS + 1;
    // A full window of differences of one sign fits in this width.
    localparam int SUM_W  = PRICE_BITS + SLOT_W;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_cfg;
    logic [LEN_W-1:0]    r_bars;
    logic [SLOT_W-1:0]   r_newest_slot;
    logic [SERIAL_W-1:0] r_newest_serial;
    logic [SUM_W-1:0]    r_up;
    logic [SUM_W-1:0]    r_down;

    // Update in flight.
    logic [SERIAL_W-1:0] r_serial;
    logic [DIFF_W-1:0]   r_diff;
    t_kind               r_kind;
    logic [SLOT_W-1:0]   r_slot;
    logic                r_drop;
    logic [SUM_W-1:0]    r_total;
    logic [INDEX_W-1:0]  r_index;

    // Difference ring and its registered read data.
    logic [DIFF_W-1:0]   r_ring [WINDOW_MAX];
    logic [DIFF_W-1:0]   r_rd_data;

    // Output register.
    logic                r_out_valid;
    logic [SERIAL_W-1:0] r_out_serial;
    logic [INDEX_W-1:0]  r_out_index;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]    w_len;
    logic                w_held;
    logic                w_same;
    logic                w_next;
    logic [CMP_W-1:0]    w_slot_inc;
    logic [SLOT_W-1:0]   w_slot_next;
    t_kind               w_kind;
    logic [SLOT_W-1:0]   w_slot;
    logic [DIFF_W-1:0]   w_diff;

    logic                w_rem_neg;
    logic [DIFF_W-1:0]   w_rem_mag;
    logic [SUM_W-1:0]    w_rem_sum;
    logic                w_add_neg;
    logic [DIFF_W-1:0]   w_add_mag;
    logic [SUM_W-1:0]    w_add_sum;
    logic                w_do_remove;
    logic                w_full;
    logic                w_total_zero;

    logic                w_accept;
    logic                w_mem_re;
    logic                w_update;
    logic                w_add;
    logic                w_sum_total;
    logic                w_div_start;
    logic                w_zero_load;
    logic                w_div_take;
    logic                w_out_free;
    logic                w_out_load;

    logic                w_div_done;
    logic [INDEX_W-1:0]  w_div_quot;

    // A length of zero acts as one, and a length beyond the ring acts as the
    // ring's depth.
    always_comb begin
        if (r_cfg == '0) begin
            w_len = LEN_W'(1);
        end else if (int'(r_cfg) > WINDOW_MAX) begin
            w_len = LEN_W'(WINDOW_MAX);
        end else begin
            w_len = LEN_W'(r_cfg);
        end
    end

    // Classify the update against the newest bar held.
    assign w_held      = r_bars != '0;
    assign w_same      = w_held && (i_bar_serial == r_newest_serial);
    assign w_next      = w_held && (i_bar_serial == r_newest_serial + SERIAL_W'(1));
    assign w_slot_inc  = CMP_W'(r_newest_slot) + CMP_W'(1);
    assign w_slot_next = (w_slot_inc >= CMP_W'(w_len)) ? '0 : w_slot_inc[SLOT_W-1:0];
    assign w_diff      = DIFF_W'(i_close_price) - DIFF_W'(i_open_price);

    always_comb begin
        priority if (w_same) begin
            w_kind = KIND_SAME;
            w_slot = r_newest_slot;
        end else if (w_next) begin
            w_kind = KIND_APPEND;
            w_slot = w_slot_next;
        end else begin
            w_kind = KIND_RESTART;
            w_slot = '0;
        end
    end

    // Magnitudes of the difference leaving and the one entering the sums.
    // A difference of zero counts as an up move.
    assign w_rem_neg   = r_rd_data[DIFF_W-1];
    assign w_rem_mag   = w_rem_neg ? (DIFF_W'(0) - r_rd_data) : r_rd_data;
    assign w_rem_sum   = SUM_W'(w_rem_mag[PRICE_BITS-1:0]);
    assign w_add_neg   = r_diff[DIFF_W-1];
    assign w_add_mag   = w_add_neg ? (DIFF_W'(0) - r_diff) : r_diff;
    assign w_add_sum   = SUM_W'(w_add_mag[PRICE_BITS-1:0]);

    assign w_do_remove  = (r_kind == KIND_SAME) || ((r_kind == KIND_APPEND) && r_drop);
    assign w_full       = r_bars >= w_len;
    assign w_total_zero = r_total == '0;
    assign w_out_free   = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_REMOVE;
            end
            ST_REMOVE: begin
                n_state = ST_ADD;
            end
            ST_ADD: begin
                // The bar count has already been updated, so a window that
                // is still filling ends the update here without a result.
                n_state = w_full ? ST_TOTAL : ST_IDLE;
            end
            ST_TOTAL: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = w_total_zero ? ST_OUTPUT : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (w_div_done) begin
                    n_state = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready  = 1'b0;
        w_accept    = 1'b0;
        w_mem_re    = 1'b0;
        w_update    = 1'b0;
        w_add       = 1'b0;
        w_sum_total = 1'b0;
        w_div_start = 1'b0;
        w_zero_load = 1'b0;
        w_div_take  = 1'b0;
        w_out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_accept   = i_in_valid;
            end
            ST_READ: begin
                w_mem_re = 1'b1;
            end
            ST_REMOVE: begin
                w_update = 1'b1;
            end
            ST_ADD: begin
                w_add = 1'b1;
            end
            ST_TOTAL: begin
                w_sum_total = 1'b1;
            end
            ST_START: begin
                w_div_start = !w_total_zero;
                w_zero_load = w_total_zero;
            end
            ST_DIVIDE: begin
                w_div_take = w_div_done;
            end
            ST_OUTPUT: begin
                w_out_load = w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_cfg           <= CFG_RESET;
            r_bars          <= '0;
            r_newest_slot   <= '0;
            r_newest_serial <= '0;
            r_up            <= '0;
            r_down          <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_accept) begin
                r_newest_serial <= i_bar_serial;
            end

            if (i_cfg_we) begin
                // A new window length restarts the window.
                r_cfg         <= i_cfg_wdata;
                r_bars        <= '0;
                r_newest_slot <= '0;
                r_up          <= '0;
                r_down        <= '0;
            end else if (w_update) begin
                r_newest_slot <= r_slot;
                unique case (r_kind)
                    KIND_SAME: begin
                        r_bars <= r_bars;
                    end
                    KIND_APPEND: begin
                        r_bars <= r_drop ? w_len : r_bars + LEN_W'(1);
                    end
                    KIND_RESTART: begin
                        r_bars <= LEN_W'(1);
                    end
                    default: begin
                        r_bars <= r_bars;
                    end
                endcase
                if (r_kind == KIND_RESTART) begin
                    r_up   <= '0;
                    r_down <= '0;
                end else if (w_do_remove) begin
                    if (w_rem_neg) begin
                        r_down <= r_down - w_rem_sum;
                    end else begin
                        r_up <= r_up - w_rem_sum;
                    end
                end
            end else if (w_add) begin
                if (w_add_neg) begin
                    r_down <= r_down + w_add_sum;
                end else begin
                    r_up <= r_up + w_add_sum;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_serial <= i_bar_serial;
            r_diff   <= w_diff;
            r_kind   <= w_kind;
            r_slot   <= w_slot;
            r_drop   <= w_full;
        end
        if (w_sum_total) begin
            r_total <= r_up + r_down;
        end
        if (w_zero_load) begin
            r_index <= '0;
        end else if (w_div_take) begin
            r_index <= w_div_quot;
        end
        if (w_out_load) begin
            r_out_serial <= r_serial;
            r_out_index  <= r_index;
        end
    end

    // ------------------------------------------------------------------
    // Difference ring: one read port and one write port, read registered.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_update) begin
            r_ring[r_slot] <= r_diff;
        end
        if (w_mem_re) begin
            r_rd_data <= r_ring[r_slot];
        end
    end

    // ------------------------------------------------------------------
    // Ratio divider
    // ------------------------------------------------------------------
    wrsi_divider #(
        .SUM_W (SUM_W)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_up       (r_up),
        .i_total    (r_total),
        .o_done     (w_div_done),
        .o_quotient (w_div_quot)
    );

    assign o_out_valid        = r_out_valid;
    assign o_result_serial    = r_out_serial;
    assign o_index_hundredths = r_out_index;

endmodule
